### sv/sdr_pkg.sv
// shared types and constants for the soft-disk repulsion force block
// no dependencies; imported by every module of the block
package sdr_pkg;

    localparam int POS_W           = 24;
    localparam int IDX_W           = 9;
    localparam int CNT_W           = 10;
    localparam int STIFF_W         = 16;
    localparam int FORCE_W         = 40;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    localparam int POS_FRAC_BITS   = 16;
    localparam int STIFF_FRAC_BITS = 8;
    localparam int FORCE_FRAC_BITS = 16;
    localparam int FORCE_SHIFT     = STIFF_FRAC_BITS + POS_FRAC_BITS - FORCE_FRAC_BITS;

    localparam int D_W    = POS_W + 2;
    localparam int SQ_W   = 2 * POS_W;
    localparam int ROOT_W = POS_W;
    localparam int G_W    = STIFF_W + POS_W - FORCE_SHIFT;
    localparam int PROD_W = G_W + POS_W;
    localparam int TERM_W = G_W + 1;
    localparam int ACC_W  = G_W + IDX_W + 1;

    localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_WIDTH        = 3'd0,
        CFG_BOX_HEIGHT       = 3'd1,
        CFG_CONTACT_DISTANCE = 3'd2,
        CFG_STIFFNESS        = 3'd3,
        CFG_PARTICLE_COUNT   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] particle_index;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } sdr_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]          result_index;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
    } sdr_out_t;

    typedef struct packed {
        logic             mem_write;
        logic             latch_query;
        logic             acc_clear;
        logic             rd_en;
        logic             rd_self;
        logic             latch_self;
        logic             issue;
        logic [CNT_W-1:0] rd_addr;
        logic             out_load;
    } sdr_cmd_t;

    typedef struct packed {
        logic             idx_ok;
        logic [CNT_W-1:0] n_eff;
        logic             busy;
        logic             out_full;
    } sdr_stat_t;

endpackage

### sv/soft_disk_repulsion_forces.sv
// a force query walks n slots from its transfer to a valid result, n being
// min(particle_count, MAX_PARTICLES): one pair per cycle leaves the position store read port,
// then the 63-stage pair unit (displacement, square root, spring and divide stages) drains
// into the sums
// throughput: one query at a time, one write per cycle
// reset: synchronous active low, restores the configuration registers and clears control
// state; the position store is not cleared and holds garbage until written
module soft_disk_repulsion_forces
    import sdr_pkg::*;
#(
    parameter int MAX_PARTICLES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel: writes and queries
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sdr_in_t               s_data,
    // result channel: one transfer per query
    output logic                  m_valid,
    input  logic                  m_ready,
    output sdr_out_t              m_data
);

    // command and status between controller and datapath
    sdr_cmd_t  cmd;
    sdr_stat_t stat;

    // controller: accepts requests only when idle, walks slots 0..n-1 for a query
    sdr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_data.req_type),
        .s_ready    (s_ready),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: store, pair pipeline, saturating result register
    sdr_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### sv/sdr_pair_unit.sv
// pipelined pair force unit: minimum image, cutoff, square root, spring term, divide
// one pair enters per cycle; depends on sdr_pkg
module sdr_pair_unit
    import sdr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic                     in_skip,
    input  logic [POS_W-1:0]         xi,
    input  logic [POS_W-1:0]         yi,
    input  logic [POS_W-1:0]         xj,
    input  logic [POS_W-1:0]         yj,
    input  logic [POS_W-1:0]         box_w,
    input  logic [POS_W-1:0]         box_h,
    input  logic [POS_W-1:0]         contact,
    input  logic [SQ_W-1:0]          contact_sq,
    input  logic [STIFF_W-1:0]       stiffness,
    output logic                     out_valid,
    output logic signed [TERM_W-1:0] term_x,
    output logic signed [TERM_W-1:0] term_y,
    output logic                     busy
);

    localparam int SUM_W = 2 * D_W + 1;
    localparam int REM_W = ROOT_W + 3;

    function automatic logic signed [D_W-1:0] wrap_down(
        input logic signed [D_W-1:0] d,
        input logic [POS_W-1:0]      len
    );
        logic signed [D_W:0] twice;
        logic signed [D_W:0] len_ext;
        twice   = {d, 1'b0};
        len_ext = $signed({3'b000, len});
        if (twice > len_ext) begin
            return d - $signed({2'b00, len});
        end
        return d;
    endfunction

    function automatic logic signed [D_W-1:0] wrap_up(
        input logic signed [D_W-1:0] d,
        input logic [POS_W-1:0]      len
    );
        logic signed [D_W:0] twice;
        logic signed [D_W:0] len_ext;
        twice   = {d, 1'b0};
        len_ext = $signed({3'b000, len});
        if (twice < -len_ext) begin
            return d + $signed({2'b00, len});
        end
        return d;
    endfunction

    // front stages
    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  skip1_reg, skip2_reg, skip3_reg, skip4_reg;
    logic signed [D_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [D_W-1:0] dx4_reg, dy4_reg;
    logic [2*D_W-1:0]      sqx4_reg, sqy4_reg;
    logic signed [2*D_W-1:0] sqx_next, sqy_next;
    logic [SUM_W-1:0]      sum5;
    logic                  pass5;

    // square root stages, index 0 holds the squared distance
    logic [ROOT_W:0]       sv_reg;
    logic [SQ_W-1:0]       rad_reg  [ROOT_W+1];
    logic [REM_W-1:0]      rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]     root_reg [ROOT_W+1];
    logic signed [D_W-1:0] sdx_reg  [ROOT_W+1];
    logic signed [D_W-1:0] sdy_reg  [ROOT_W+1];
    logic [REM_W-1:0]      sq_cur   [ROOT_W];
    logic [REM_W-1:0]      sq_trial [ROOT_W];

    // spring magnitude stage
    logic                         gv_reg;
    logic [G_W-1:0]               g_reg;
    logic [POS_W-1:0]             ax_reg, ay_reg, gr_reg;
    logic                         gsx_reg, gsy_reg;
    logic [POS_W-1:0]             r_fin;
    logic [STIFF_W+POS_W-1:0]     gprod;
    logic signed [D_W-1:0]        mag_x, mag_y;
    logic [PROD_W-1:0]            px_next, py_next;

    // divider stages, index 0 holds the products
    logic [G_W:0]      dv_reg;
    logic [POS_W-1:0]  xrem_reg [G_W+1];
    logic [POS_W-1:0]  yrem_reg [G_W+1];
    logic [G_W-1:0]    xlow_reg [G_W+1];
    logic [G_W-1:0]    ylow_reg [G_W+1];
    logic [G_W-1:0]    xq_reg   [G_W+1];
    logic [G_W-1:0]    yq_reg   [G_W+1];
    logic [POS_W-1:0]  dr_reg   [G_W+1];
    logic              dsx_reg  [G_W+1];
    logic              dsy_reg  [G_W+1];
    logic [POS_W:0]    xcur [G_W];
    logic [POS_W:0]    ycur [G_W];

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            sv_reg <= '0;
            gv_reg <= 1'b0;
            dv_reg <= '0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            sv_reg <= {sv_reg[ROOT_W-1:0], pass5};
            gv_reg <= sv_reg[ROOT_W];
            dv_reg <= {dv_reg[G_W-1:0], gv_reg};
        end
    end

    assign sqx_next = dx3_reg * dx3_reg;
    assign sqy_next = dy3_reg * dy3_reg;
    assign sum5     = {1'b0, sqx4_reg} + {1'b0, sqy4_reg};
    assign pass5    = v4_reg && !skip4_reg && (sum5 != '0)
                      && (sum5 <= (SUM_W)'(contact_sq));

    // displacement, two wrap steps, squares
    always_ff @(posedge aclk) begin
        skip1_reg <= in_skip;
        dx1_reg   <= $signed({2'b00, xi}) - $signed({2'b00, xj});
        dy1_reg   <= $signed({2'b00, yi}) - $signed({2'b00, yj});
        skip2_reg <= skip1_reg;
        dx2_reg   <= wrap_down(dx1_reg, box_w);
        dy2_reg   <= wrap_down(dy1_reg, box_h);
        skip3_reg <= skip2_reg;
        dx3_reg   <= wrap_up(dx2_reg, box_w);
        dy3_reg   <= wrap_up(dy2_reg, box_h);
        skip4_reg <= skip3_reg;
        dx4_reg   <= dx3_reg;
        dy4_reg   <= dy3_reg;
        sqx4_reg  <= sqx_next;
        sqy4_reg  <= sqy_next;
    end

    // restoring square root, one root bit per stage
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            sq_cur[k]   = {rem_reg[k][REM_W-3:0], rad_reg[k][SQ_W-1 -: 2]};
            sq_trial[k] = (REM_W)'({root_reg[k], 2'b01});
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg[0]  <= sum5[SQ_W-1:0];
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        sdx_reg[0]  <= dx4_reg;
        sdy_reg[0]  <= dy4_reg;
        for (int k = 0; k < ROOT_W; k++) begin
            rad_reg[k+1] <= rad_reg[k] << 2;
            sdx_reg[k+1] <= sdx_reg[k];
            sdy_reg[k+1] <= sdy_reg[k];
            if (sq_cur[k] >= sq_trial[k]) begin
                rem_reg[k+1]  <= sq_cur[k] - sq_trial[k];
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg[k+1]  <= sq_cur[k];
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // spring magnitude g and axis magnitudes
    assign r_fin = root_reg[ROOT_W];
    assign gprod = stiffness * (contact - r_fin);
    assign mag_x = sdx_reg[ROOT_W] < 0 ? -sdx_reg[ROOT_W] : sdx_reg[ROOT_W];
    assign mag_y = sdy_reg[ROOT_W] < 0 ? -sdy_reg[ROOT_W] : sdy_reg[ROOT_W];

    always_ff @(posedge aclk) begin
        g_reg   <= gprod[FORCE_SHIFT +: G_W];
        ax_reg  <= mag_x[POS_W-1:0];
        ay_reg  <= mag_y[POS_W-1:0];
        gsx_reg <= sdx_reg[ROOT_W] < 0;
        gsy_reg <= sdy_reg[ROOT_W] < 0;
        gr_reg  <= r_fin;
    end

    assign px_next = g_reg * ax_reg;
    assign py_next = g_reg * ay_reg;

    // restoring divide by r, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < G_W; k++) begin
            xcur[k] = {xrem_reg[k], xlow_reg[k][G_W-1]};
            ycur[k] = {yrem_reg[k], ylow_reg[k][G_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        xrem_reg[0] <= px_next[PROD_W-1 -: POS_W];
        yrem_reg[0] <= py_next[PROD_W-1 -: POS_W];
        xlow_reg[0] <= px_next[G_W-1:0];
        ylow_reg[0] <= py_next[G_W-1:0];
        xq_reg[0]   <= '0;
        yq_reg[0]   <= '0;
        dr_reg[0]   <= gr_reg;
        dsx_reg[0]  <= gsx_reg;
        dsy_reg[0]  <= gsy_reg;
        for (int k = 0; k < G_W; k++) begin
            xlow_reg[k+1] <= xlow_reg[k] << 1;
            ylow_reg[k+1] <= ylow_reg[k] << 1;
            dr_reg[k+1]   <= dr_reg[k];
            dsx_reg[k+1]  <= dsx_reg[k];
            dsy_reg[k+1]  <= dsy_reg[k];
            if (xcur[k] >= {1'b0, dr_reg[k]}) begin
                xrem_reg[k+1] <= POS_W'(xcur[k] - {1'b0, dr_reg[k]});
                xq_reg[k+1]   <= {xq_reg[k][G_W-2:0], 1'b1};
            end else begin
                xrem_reg[k+1] <= xcur[k][POS_W-1:0];
                xq_reg[k+1]   <= {xq_reg[k][G_W-2:0], 1'b0};
            end
            if (ycur[k] >= {1'b0, dr_reg[k]}) begin
                yrem_reg[k+1] <= POS_W'(ycur[k] - {1'b0, dr_reg[k]});
                yq_reg[k+1]   <= {yq_reg[k][G_W-2:0], 1'b1};
            end else begin
                yrem_reg[k+1] <= ycur[k][POS_W-1:0];
                yq_reg[k+1]   <= {yq_reg[k][G_W-2:0], 1'b0};
            end
        end
    end

    assign out_valid = dv_reg[G_W];
    assign term_x = dsx_reg[G_W] ? -$signed({1'b0, xq_reg[G_W]}) : $signed({1'b0, xq_reg[G_W]});
    assign term_y = dsy_reg[G_W] ? -$signed({1'b0, yq_reg[G_W]}) : $signed({1'b0, yq_reg[G_W]});
    assign busy = v1_reg | v2_reg | v3_reg | v4_reg | (|sv_reg) | gv_reg | (|dv_reg);

endmodule

### sv/sdr_datapath.sv
// datapath: config registers, position store, pair unit, force sums, result register
// depends on sdr_pkg and sdr_pair_unit
module sdr_datapath
    import sdr_pkg::*;
#(
    parameter int MAX_PARTICLES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  sdr_in_t               s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output sdr_out_t              m_data,
    input  sdr_cmd_t              cmd,
    output sdr_stat_t             stat
);

    localparam int AW = $clog2(MAX_PARTICLES);

    function automatic logic signed [FORCE_W-1:0] saturate(input logic signed [ACC_W-1:0] v);
        if (v > (ACC_W)'(FORCE_MAX)) begin
            return FORCE_MAX;
        end
        if (v < (ACC_W)'(FORCE_MIN)) begin
            return FORCE_MIN;
        end
        return v[FORCE_W-1:0];
    endfunction

    logic [POS_W-1:0]   box_w_reg, box_h_reg, contact_reg;
    logic [STIFF_W-1:0] stiff_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SQ_W-1:0]    contact_sq_reg;

    logic [2*POS_W-1:0] mem [MAX_PARTICLES];
    logic [2*POS_W-1:0] rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_skip_reg;
    logic [31:0]        wr_ext, rd_ext;
    logic [AW-1:0]      wr_addr, rd_addr;

    logic [IDX_W-1:0]   q_idx_reg;
    logic [POS_W-1:0]   xi_reg, yi_reg;

    logic                     pu_valid, pu_busy;
    logic signed [TERM_W-1:0] pu_tx, pu_ty;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;

    logic     out_valid_reg;
    sdr_out_t out_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_w_reg   <= POS_W'(1572864);
            box_h_reg   <= POS_W'(1572864);
            contact_reg <= POS_W'(65536);
            stiff_reg   <= STIFF_W'(30720);
            count_reg   <= CNT_W'(500);
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_BOX_WIDTH:        box_w_reg   <= cfg_wdata[POS_W-1:0];
                CFG_BOX_HEIGHT:       box_h_reg   <= cfg_wdata[POS_W-1:0];
                CFG_CONTACT_DISTANCE: contact_reg <= cfg_wdata[POS_W-1:0];
                CFG_STIFFNESS:        stiff_reg   <= cfg_wdata[STIFF_W-1:0];
                CFG_PARTICLE_COUNT:   count_reg   <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        contact_sq_reg <= contact_reg * contact_reg;
    end

    // position store
    assign wr_ext  = 32'(s_data.particle_index);
    assign rd_ext  = cmd.rd_self ? 32'(q_idx_reg) : 32'(cmd.rd_addr);
    assign wr_addr = wr_ext[AW-1:0];
    assign rd_addr = rd_ext[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            mem[wr_addr] <= {s_data.pos_x, s_data.pos_y};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge aclk) begin
        rd_skip_reg <= (cmd.rd_addr == CNT_W'(q_idx_reg));
        if (cmd.latch_query) begin
            q_idx_reg <= s_data.particle_index;
        end
        if (cmd.latch_self) begin
            xi_reg <= rd_data_reg[2*POS_W-1:POS_W];
            yi_reg <= rd_data_reg[POS_W-1:0];
        end
    end

    sdr_pair_unit u_pair (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rd_valid_reg),
        .in_skip    (rd_skip_reg),
        .xi         (xi_reg),
        .yi         (yi_reg),
        .xj         (rd_data_reg[2*POS_W-1:POS_W]),
        .yj         (rd_data_reg[POS_W-1:0]),
        .box_w      (box_w_reg),
        .box_h      (box_h_reg),
        .contact    (contact_reg),
        .contact_sq (contact_sq_reg),
        .stiffness  (stiff_reg),
        .out_valid  (pu_valid),
        .term_x     (pu_tx),
        .term_y     (pu_ty),
        .busy       (pu_busy)
    );

    // force sums
    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end else if (pu_valid) begin
            acc_x_reg <= acc_x_reg + (ACC_W)'(pu_tx);
            acc_y_reg <= acc_y_reg + (ACC_W)'(pu_ty);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg.result_index <= q_idx_reg;
            out_data_reg.force_x      <= saturate(acc_x_reg);
            out_data_reg.force_y      <= saturate(acc_y_reg);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign stat.idx_ok   = (32'(s_data.particle_index) < MAX_PARTICLES);
    assign stat.n_eff    = (32'(count_reg) > MAX_PARTICLES) ? (CNT_W)'(MAX_PARTICLES) : count_reg;
    assign stat.busy     = rd_valid_reg | pu_busy;
    assign stat.out_full = out_valid_reg;

endmodule

### sv/sdr_ctrl.sv
// controller: accepts transfers, sequences the pair walk of a query, hands off the result
// depends on sdr_pkg
module sdr_ctrl
    import sdr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_req_type,
    output logic      s_ready,
    input  logic      m_ready,
    input  sdr_stat_t stat,
    output sdr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_SELF,
        ST_LATCH_SELF,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] j_inc;

    assign j_inc = j_reg + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.rd_addr = j_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_WRITE) begin
                        cmd.mem_write = stat.idx_ok;
                    end else begin
                        cmd.latch_query = 1'b1;
                        cmd.acc_clear   = 1'b1;
                        state_next = stat.idx_ok ? ST_READ_SELF : ST_FINISH;
                    end
                end
            end
            ST_READ_SELF: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_self = 1'b1;
                state_next  = ST_LATCH_SELF;
            end
            ST_LATCH_SELF: begin
                cmd.latch_self = 1'b1;
                j_next     = '0;
                state_next = (stat.n_eff == '0) ? ST_DRAIN : ST_RUN;
            end
            ST_RUN: begin
                cmd.rd_en = 1'b1;
                cmd.issue = 1'b1;
                j_next    = j_inc;
                if (j_inc == stat.n_eff) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!stat.out_full || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !stat.busy)
        else $error("pair pipeline busy while idle");
    a_issue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (j_reg < stat.n_eff))
        else $error("pair issued beyond particle count");
    a_issue_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |=> stat.busy)
        else $error("issued pair not tracked as in flight");
    a_load_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.busy)
        else $error("result loaded before sums complete");
`endif

endmodule

### tb/sv/tb_soft_disk_repulsion_forces.sv
// testbench for soft_disk_repulsion_forces: position writes and force queries
// checked against a behavioral force predictor; depends on sdr_pkg and the block rtl
module tb_soft_disk_repulsion_forces;
    import sdr_pkg::*;

    localparam int SLOTS = 512;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sdr_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sdr_out_t              m_data;

    // predictor state: configuration and position store mirror
    int unsigned box_w, box_h, contact, stiff, n_count;
    logic [POS_W-1:0] x_mirror [SLOTS];
    logic [POS_W-1:0] y_mirror [SLOTS];

    sdr_out_t force_queue [$];
    int       err_count   = 0;
    int       send_idle   = 0;  // percent of cycles the sender holds off
    int       recv_stall  = 0;  // percent of cycles the receiver stalls

    soft_disk_repulsion_forces i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // minimum image along one axis
    function automatic longint min_image(longint d, longint len);
        if (2 * d > len) d -= len;
        if (2 * d < -len) d += len;
        return d;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint axis_term(longint unsigned g, longint d, longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q   = (g * mag) / r;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [FORCE_W-1:0] clamp_force(longint v);
        if (v > 64'sd549755813887) return FORCE_MAX;
        if (v < -64'sd549755813888) return FORCE_MIN;
        return v[FORCE_W-1:0];
    endfunction

    // summed repulsion on one particle from every other slot below the count
    function automatic sdr_out_t predict_force(int unsigned idx);
        sdr_out_t        res;
        longint          fx, fy, dx, dy;
        longint unsigned s, r, g, c, c2;
        int unsigned     n;
        fx = 0;
        fy = 0;
        c  = contact;
        c2 = c * c;
        n  = (n_count > SLOTS) ? SLOTS : n_count;
        for (int unsigned j = 0; j < n; j++) begin
            if (j == idx) continue;
            dx = min_image(longint'(x_mirror[idx]) - longint'(x_mirror[j]), longint'(box_w));
            dy = min_image(longint'(y_mirror[idx]) - longint'(y_mirror[j]), longint'(box_h));
            s  = longint'(dx * dx) + longint'(dy * dy);
            if (s == 0 || s > c2) continue;
            r   = int_sqrt(s);
            g   = (longint'(stiff) * (c - r)) >> FORCE_SHIFT;
            fx += axis_term(g, dx, r);
            fy += axis_term(g, dy, r);
        end
        res.result_index = idx[IDX_W-1:0];
        res.force_x      = clamp_force(fx);
        res.force_y      = clamp_force(fy);
        return res;
    endfunction

    // receiver: random stalls on the result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // result checker: every result transfer against the oldest expected force
    always @(posedge aclk) begin
        sdr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (force_queue.size() == 0) begin
                $display("%0t: unexpected result idx %0d fx %0d fy %0d", $time,
                         m_data.result_index, m_data.force_x, m_data.force_y);
                err_count++;
            end else begin
                want = force_queue.pop_front();
                if (m_data.result_index !== want.result_index) begin
                    $display("%0t: result_index expected %0d actual %0d", $time,
                             want.result_index, m_data.result_index);
                    err_count++;
                end
                if (m_data.force_x !== want.force_x) begin
                    $display("%0t: force_x idx %0d expected %0d actual %0d", $time,
                             want.result_index, want.force_x, m_data.force_x);
                    err_count++;
                end
                if (m_data.force_y !== want.force_y) begin
                    $display("%0t: force_y idx %0d expected %0d actual %0d", $time,
                             want.result_index, want.force_y, m_data.force_y);
                    err_count++;
                end
            end
        end
    end

    // one request transfer; called at a rising edge, returns at the edge of acceptance
    task automatic send_req(logic kind, int unsigned idx, int unsigned px, int unsigned py);
        sdr_in_t it;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        it.req_type       = kind;
        it.particle_index = idx[IDX_W-1:0];
        it.pos_x          = px[POS_W-1:0];
        it.pos_y          = py[POS_W-1:0];
        s_valid <= 1'b1;
        s_data  <= it;
        // predict in acceptance order
        if (kind == REQ_WRITE) begin
            x_mirror[it.particle_index] = it.pos_x;
            y_mirror[it.particle_index] = it.pos_y;
        end else begin
            force_queue.insert(force_queue.size(), predict_force(it.particle_index));
        end
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_pos(int unsigned idx, int unsigned px, int unsigned py);
        send_req(REQ_WRITE, idx, px, py);
    endtask

    task automatic query(int unsigned idx);
        send_req(REQ_QUERY, idx, 0, 0);
    endtask

    // drop valid, wait for every expected force, then let trailing writes finish
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (force_queue.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // register write; waits until the block is idle first
    task automatic set_reg(cfg_reg_t r, int unsigned v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v[CFG_DATA_W-1:0];
        case (r)
            CFG_BOX_WIDTH:        box_w   = v & 24'hFFFFFF;
            CFG_BOX_HEIGHT:       box_h   = v & 24'hFFFFFF;
            CFG_CONTACT_DISTANCE: contact = v & 24'hFFFFFF;
            CFG_STIFFNESS:        stiff   = v & 16'hFFFF;
            CFG_PARTICLE_COUNT:   n_count = v & 10'h3FF;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_all(int unsigned w, int unsigned h, int unsigned c, int unsigned k,
                           int unsigned n);
        set_reg(CFG_BOX_WIDTH, w);
        set_reg(CFG_BOX_HEIGHT, h);
        set_reg(CFG_CONTACT_DISTANCE, c);
        set_reg(CFG_STIFFNESS, k);
        set_reg(CFG_PARTICLE_COUNT, n);
    endtask

    // every slot written once so no query ever reads an unwritten slot
    task automatic test_fill_and_reset_config();
        write_pos(0, 0, 0);
        write_pos(SLOTS - 1, 24'hFFFFFF, 24'hFFFFFF);
        for (int unsigned i = 1; i < SLOTS - 1; i++)
            write_pos(i, $urandom_range(24 * 65536 - 1), $urandom_range(24 * 65536 - 1));
        // reset settings: count 500, queried slot beyond the count still answers
        query(0);
        query(499);
        query(SLOTS - 1);
        drain();
    endtask

    // self skip, empty sum, count beyond the store, coincident pair, wraparound
    task automatic test_corner_cases();
        set_all(4 * 65536, 4 * 65536, 65536, 30720, 1);
        query(0);
        set_reg(CFG_PARTICLE_COUNT, 0);
        query(3);
        set_reg(CFG_PARTICLE_COUNT, 1023);
        query(7);
        set_reg(CFG_PARTICLE_COUNT, 4);
        write_pos(0, 6554, 6554);
        write_pos(1, 6554, 6554);              // coincident with slot 0
        write_pos(2, 4 * 65536 - 6554, 6554);  // near slot 0 only across the x edge
        write_pos(3, 6554, 4 * 65536 - 6554);  // near slot 0 only across the y edge
        query(0);
        query(1);
        query(2);
        query(3);
        drain();
    endtask

    // close overlap from many slots drives both sums into saturation, both signs
    task automatic test_saturation();
        set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 65535, 200);
        for (int unsigned i = 1; i < 200; i++) write_pos(i, 24'h100000, 24'h100000);
        write_pos(0, 24'h100000 + 1024, 24'h100000 + 1024);
        query(0);
        write_pos(0, 24'h100000 - 1024, 24'h100000 - 1024);
        query(0);
        query(5);
        drain();
    endtask

    // random rounds: fresh settings, clustered positions, queries mostly inside the count
    task automatic test_random_rounds();
        int unsigned w, h, c, k, n, lim, px, py, idx;
        for (int rnd = 0; rnd < 10; rnd++) begin
            case (rnd % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 67; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 67; end
                default: begin send_idle = 7; recv_stall = 7; end
            endcase
            case ($urandom_range(9))
                0: w = 1;
                1: w = 24'hFFFFFF;
                default: w = $urandom_range(65536, 6 * 65536);
            endcase
            case ($urandom_range(9))
                0: h = 1;
                1: h = 24'hFFFFFF;
                default: h = $urandom_range(65536, 6 * 65536);
            endcase
            case ($urandom_range(9))
                0: c = 0;
                1: c = 24'hFFFFFF;
                default: c = $urandom_range(16384, 98304);
            endcase
            case ($urandom_range(7))
                0: k = 0;
                1: k = 65535;
                default: k = $urandom_range(65535);
            endcase
            case ($urandom_range(19))
                0: n = 0;
                1: n = 1;
                2: n = 512;
                3: n = $urandom_range(513, 1023);
                4: n = $urandom_range(41, 511);
                default: n = $urandom_range(2, 40);
            endcase
            set_all(w, h, c, k, n);
            lim = (n == 0) ? 1 : ((n > 40) ? 40 : n);
            for (int i = 0; i < 44; i++) begin
                if ($urandom_range(99) < 45) begin
                    idx = $urandom_range(lim - 1);
                    if ($urandom_range(9) == 0) begin
                        px = $urandom_range(24'hFFFFFF);
                        py = $urandom_range(24'hFFFFFF);
                    end else begin
                        px = $urandom_range(w - 1);
                        py = $urandom_range(h - 1);
                    end
                    write_pos(idx, px, py);
                end else begin
                    idx = ($urandom_range(9) == 0) ? $urandom_range(SLOTS - 1)
                                                   : $urandom_range(lim - 1);
                    query(idx);
                end
            end
            drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // mirror of the reset configuration
        box_w   = 1572864;
        box_h   = 1572864;
        contact = 65536;
        stiff   = 30720;
        n_count = 500;
        test_fill_and_reset_config();
        test_corner_cases();
        test_saturation();
        test_random_rounds();
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule
